>>> rtl/core/modified_base_pair_distance_counter_core_defines.svh
// assertion macros shared by the checker
`ifndef MODIFIED_BASE_PAIR_DISTANCE_COUNTER_CORE_DEFINES_SVH
`define MODIFIED_BASE_PAIR_DISTANCE_COUNTER_CORE_DEFINES_SVH

// same-cycle implication
`define MBPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbpd check failed");

// next-cycle implication
`define MBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbpd check failed");

`endif

>>> rtl/core/mbpd_pkg.sv
package mbpd_pkg;

    localparam int POS_W = 31;

    // configuration register indexes
    localparam logic [2:0] CFG_UNMOD_FWD = 3'd0;
    localparam logic [2:0] CFG_MOD_FWD   = 3'd1;
    localparam logic [2:0] CFG_UNMOD_REV = 3'd2;
    localparam logic [2:0] CFG_MOD_REV   = 3'd3;
    localparam logic [2:0] CFG_WINDOW    = 3'd4;

    // configuration reset values
    localparam logic [3:0] RST_UNMOD_FWD = 4'd8;
    localparam logic [3:0] RST_MOD_FWD   = 4'd2;
    localparam logic [3:0] RST_UNMOD_REV = 4'd1;
    localparam logic [3:0] RST_MOD_REV   = 4'd4;
    localparam logic [5:0] RST_WINDOW    = 6'd32;

    // request types
    localparam logic REQ_BASE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [POS_W-1:0] ref_pos;
        logic [3:0]       base_code;
        logic             in_context;
        logic             reverse_strand;
        logic             last_of_read;
        logic [4:0]       bin_distance;
        logic [1:0]       bin_pair_state;
    } t_in_word;

    typedef struct packed {
        logic [31:0] bin_count;
        logic        was_called;
        logic        call_state;
    } t_out_word;

    // one stored call
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        logic             st;
    } t_cell;

    // histogram access request
    typedef struct packed {
        logic bump;
        logic rd;
    } t_hist_op;

endpackage

>>> rtl/core/mbpd_cell.sv
module mbpd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic               i_clr,
    input  mbpd_pkg::t_cell    i_cell,
    output mbpd_pkg::t_cell    o_cell
);

    logic                       r_valid;
    logic [mbpd_pkg::POS_W-1:0] r_pos;
    logic                       r_st;
    logic                       n_valid;

    // valid bit follows the chain, cleared at end of read
    always_comb begin
        n_valid = r_valid;
        if (i_shift) begin
            n_valid = i_cell.valid;
        end
        if (i_clr) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // call payload taken from the left neighbour
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pos <= i_cell.pos;
            r_st  <= i_cell.st;
        end
    end

    assign o_cell = '{valid: r_valid, pos: r_pos, st: r_st};

endmodule

>>> rtl/core/mbpd_hist.sv
module mbpd_hist #(
    parameter int WINDOW_MAX = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mbpd_pkg::t_hist_op                   i_op,
    input  logic [$clog2(WINDOW_MAX)+1:0]        i_addr,
    output logic                                 o_busy,
    output logic [COUNT_BITS-1:0]                o_rd_data
);

    localparam int AW    = $clog2(WINDOW_MAX) + 2;
    localparam int DEPTH = WINDOW_MAX * 4;

    logic [COUNT_BITS-1:0] r_mem [0:DEPTH-1];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [COUNT_BITS-1:0] r_wr_val;
    logic [AW-1:0]         r_p_addr;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_busy;
    logic                  r_p_bump;
    logic                  r_fwd;
    logic [COUNT_BITS-1:0] w_base;
    logic [COUNT_BITS-1:0] n_inc;

    // saturating increment, forwarded from the write just made
    always_comb begin
        w_base = r_fwd ? r_wr_val : r_rd_data;
        n_inc  = (w_base == {COUNT_BITS{1'b1}}) ? w_base : w_base + 1'b1;
    end

    // memory: clearing pass, then read-modify-write
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_p_bump) begin
            r_mem[r_p_addr] <= n_inc;
        end
        if (i_op.bump || i_op.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // write-stage payload
    always_ff @(posedge i_clk) begin
        r_p_addr <= i_addr;
        r_wr_val <= n_inc;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_p_bump   <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (r_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            r_p_bump <= i_op.bump;
            r_fwd    <= i_op.bump && r_p_bump && (i_addr == r_p_addr);
        end
    end

    assign o_busy    = r_busy;
    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/modified_base_pair_distance_counter_core.sv
// a call word reaches its result through one ring pass over the cell chain (SCAN)
// feeding one histogram update a cycle at most, then SELF for its own pair and the insert
// a base that is no call goes straight to DONE, a bin read through RDREQ and RDWAIT first
// one word is in work at a time; ready returns in the cycle after the result is registered
// reset is synchronous, active low; it empties the call history and then the histogram is
// cleared one bin a cycle over all WINDOW_MAX * 4 bins, during which no word is taken
module modified_base_pair_distance_counter_core #(
    parameter int WINDOW_MAX = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mbpd_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mbpd_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [5:0]           i_cfg_data
);

    localparam int AW = $clog2(WINDOW_MAX) + 2;
    localparam int CW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SELF   = 3'd3;
    localparam logic [2:0] ST_RDREQ  = 3'd4;
    localparam logic [2:0] ST_RDWAIT = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]                 r_state;
    logic [CW-1:0]              r_cnt;
    logic [3:0]                 r_unmod_fwd;
    logic [3:0]                 r_mod_fwd;
    logic [3:0]                 r_unmod_rev;
    logic [3:0]                 r_mod_rev;
    logic [5:0]                 r_window;
    logic [mbpd_pkg::POS_W-1:0] r_pos;
    logic                       r_st;
    logic                       r_last;
    logic [4:0]                 r_bdist;
    logic [1:0]                 r_bstate;
    mbpd_pkg::t_out_word        r_res;
    mbpd_pkg::t_out_word        r_out_word;
    logic                       r_out_valid;

    logic                       w_accept;
    logic [3:0]                 w_um;
    logic [3:0]                 w_md;
    logic                       w_call;
    logic                       w_st;
    logic [5:0]                 w_win;
    mbpd_pkg::t_cell            w_chain [0:WINDOW_MAX-1];
    mbpd_pkg::t_cell            w_tail;
    mbpd_pkg::t_cell            w_head_in;
    logic                       w_shift;
    logic                       w_clr;
    logic [mbpd_pkg::POS_W-1:0] w_dist;
    logic                       w_hit;
    mbpd_pkg::t_hist_op         w_op;
    logic [AW-1:0]              w_addr;
    logic                       w_busy;
    logic [COUNT_BITS-1:0]      w_rd_data;
    logic [63:0]                w_rd64;
    logic [31:0]                w_rd32;
    logic                       w_bin_ok;
    logic                       w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // classification of the incoming base
    always_comb begin
        w_um   = i_in_word.reverse_strand ? r_unmod_rev : r_unmod_fwd;
        w_md   = i_in_word.reverse_strand ? r_mod_rev : r_mod_fwd;
        w_call = i_in_word.in_context && ((i_in_word.base_code & (w_um | w_md)) != 4'd0);
        w_st   = (i_in_word.base_code != w_um);
        w_win  = (32'(r_window) > 32'(WINDOW_MAX)) ? 6'(WINDOW_MAX) : r_window;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unmod_fwd <= mbpd_pkg::RST_UNMOD_FWD;
            r_mod_fwd   <= mbpd_pkg::RST_MOD_FWD;
            r_unmod_rev <= mbpd_pkg::RST_UNMOD_REV;
            r_mod_rev   <= mbpd_pkg::RST_MOD_REV;
            r_window    <= mbpd_pkg::RST_WINDOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mbpd_pkg::CFG_UNMOD_FWD: r_unmod_fwd <= i_cfg_data[3:0];
                mbpd_pkg::CFG_MOD_FWD:   r_mod_fwd   <= i_cfg_data[3:0];
                mbpd_pkg::CFG_UNMOD_REV: r_unmod_rev <= i_cfg_data[3:0];
                mbpd_pkg::CFG_MOD_REV:   r_mod_rev   <= i_cfg_data[3:0];
                mbpd_pkg::CFG_WINDOW:    r_window    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // call history: ring of cells, new call enters at the head
    assign w_tail    = w_chain[WINDOW_MAX-1];
    assign w_shift   = (r_state == ST_SCAN) || (r_state == ST_SELF);
    assign w_clr     = (w_accept && (i_in_word.req_type == mbpd_pkg::REQ_BASE) && !w_call &&
                        i_in_word.last_of_read) || ((r_state == ST_SELF) && r_last);
    assign w_head_in = (r_state == ST_SELF) ? '{valid: 1'b1, pos: r_pos, st: r_st} : w_tail;

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        mbpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_clr   (w_clr),
            .i_cell  ((k == 0) ? w_head_in : w_chain[(k == 0) ? 0 : k-1]),
            .o_cell  (w_chain[k])
        );
    end

    // pair test on the word leaving the tail
    always_comb begin
        w_dist = r_pos - w_tail.pos;
        w_hit  = w_tail.valid && (w_tail.pos <= r_pos) && ({1'b0, w_dist} < 32'(w_win));
    end

    // histogram request
    always_comb begin
        w_op.bump = ((r_state == ST_SCAN) && w_hit) ||
                    ((r_state == ST_SELF) && (w_win != 6'd0));
        w_op.rd   = (r_state == ST_RDREQ);
        case (r_state)
            ST_SCAN: w_addr = AW'({w_dist[5:0], w_tail.st, r_st});
            ST_SELF: w_addr = AW'({6'd0, r_st, r_st});
            default: w_addr = AW'({r_bdist, r_bstate});
        endcase
    end

    mbpd_hist #(
        .WINDOW_MAX (WINDOW_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_addr    (w_addr),
        .o_busy    (w_busy),
        .o_rd_data (w_rd_data)
    );

    // bin value clipped to 32 bits
    always_comb begin
        w_rd64   = 64'(w_rd_data);
        w_rd32   = (w_rd64[63:32] != 32'd0) ? 32'hFFFF_FFFF : w_rd64[31:0];
        w_bin_ok = (32'(r_bdist) < 32'(WINDOW_MAX));
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (!w_busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept) begin
                        if (i_in_word.req_type == mbpd_pkg::REQ_READ) begin
                            r_state <= ST_RDREQ;
                        end else if (w_call) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(WINDOW_MAX - 1)) begin
                        r_state <= ST_SELF;
                    end
                end
                ST_SELF:   r_state <= ST_DONE;
                ST_RDREQ:  r_state <= ST_RDWAIT;
                ST_RDWAIT: r_state <= ST_DONE;
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:   r_state <= ST_CLEAR;
            endcase
        end
    end

    // word held while in work, result built alongside
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos    <= i_in_word.ref_pos;
            r_st     <= w_st;
            r_last   <= i_in_word.last_of_read;
            r_bdist  <= i_in_word.bin_distance;
            r_bstate <= i_in_word.bin_pair_state;
            r_res    <= '{bin_count: 32'd0,
                          was_called: (i_in_word.req_type == mbpd_pkg::REQ_BASE) && w_call,
                          call_state: (i_in_word.req_type == mbpd_pkg::REQ_BASE) && w_call
                                      && w_st};
        end else if (r_state == ST_RDWAIT) begin
            r_res.bin_count <= w_bin_ok ? w_rd32 : 32'd0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_word <= r_res;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> rtl/core/mbpd_chk.sv
`include "modified_base_pair_distance_counter_core_defines.svh"

module mbpd_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input mbpd_pkg::t_out_word  o_out_word
);

    // a stalled result word holds
    `MBPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word))

    // one word in work at a time
    `MBPD_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // no call means no call state
    `MBPD_ASSERT_NOW(a_state_needs_call, i_clk, i_rst_n, o_out_valid && !o_out_word.was_called, !o_out_word.call_state)

    // a bin value only comes with a read, never with a call
    `MBPD_ASSERT_NOW(a_count_not_call, i_clk, i_rst_n, o_out_valid && (o_out_word.bin_count != 32'd0), !o_out_word.was_called)

endmodule

bind modified_base_pair_distance_counter_core mbpd_chk u_mbpd_chk (.*);
